// ===== hw/rtl/array_tree_analyzer_assert.svh =====
// assertion macros for the tree analyzer checker
`ifndef ARRAY_TREE_ANALYZER_ASSERT_SVH
`define ARRAY_TREE_ANALYZER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ATA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ATA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/ata_pkg.sv =====
package ata_pkg;

   localparam logic [31:0] ABSENT   = 32'hFFFF_FFFF;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_ANALYZE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SC_NODE,
      ST_SC_LEFT,
      ST_SC_RIGHT,
      ST_SC_EVAL,
      ST_WK_READ,
      ST_WK_CHECK,
      ST_WK_POP,
      ST_WK_VISIT,
      ST_Q_NODE,
      ST_Q_PARENT,
      ST_Q_LEFT,
      ST_Q_RIGHT,
      ST_Q_EVAL,
      ST_RESP
   } ata_state_type;

endpackage

// ===== hw/rtl/array_tree_analyzer.sv =====
// clear and append transfers are taken while idle; busy stays low after them
// analyze: a scan of every stored entry (node, left, right, eval), the in-order walk
// (read, check, pop, visit), the query reads (node, parent, left, right, eval), then
// the response; busy is high until it ends; all steps share one node memory read port
// rsp_valid strobes for one cycle, the receiver cannot stall
// synchronous reset empties the tree; node memory contents stay undefined
module array_tree_analyzer
   import ata_pkg::*;
#(
   parameter int MAX_NODES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_node_value,
   input  logic [6:0]         req_query_index,
   output logic               rsp_valid,
   output logic               rsp_tree_empty,
   output logic               rsp_has_gaps,
   output logic [6:0]         rsp_internal_count,
   output logic [6:0]         rsp_leaf_count,
   output logic               rsp_bst_ok,
   output logic               rsp_query_valid,
   output logic signed [31:0] rsp_query_value,
   output logic               rsp_has_parent,
   output logic signed [31:0] rsp_parent_value,
   output logic signed [31:0] rsp_left_value,
   output logic signed [31:0] rsp_right_value,
   output logic [1:0]         rsp_degree
);

   localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW   = $clog2(MAX_NODES + 1);
   localparam int CURW = $clog2(2 * MAX_NODES + 1);

   ata_state_type state_ff, state_in;

   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            node_pres_ff, node_pres_in;
   logic            lpres_ff, lpres_in;
   logic            any_ff, any_in;
   logic            gap_ff, gap_in;
   logic            seen_ff, seen_in;
   logic [CW-1:0]   int_ff, int_in;
   logic [CW-1:0]   leaf_ff, leaf_in;
   logic [CURW-1:0] cur_ff, cur_in;
   logic [CW-1:0]   sp_ff, sp_in;
   logic [31:0]     prev_ff, prev_in;
   logic            ok_ff, ok_in;
   logic [6:0]      q_ff, q_in;
   logic            qpres_ff, qpres_in;
   logic [31:0]     qv_ff, qv_in;
   logic [31:0]     pv_ff, pv_in;
   logic [31:0]     lv_ff, lv_in;
   logic [31:0]     rv_ff, rv_in;

   logic [31:0]     node_store [MAX_NODES];
   logic [AW-1:0]   walk_stack [MAX_NODES];
   logic [31:0]     rd_data_ff;
   logic [AW-1:0]   stk_data_ff;
   logic [AW-1:0]   rd_addr;
   logic            wr_en;
   logic            stk_we;
   logic [AW-1:0]   stk_raddr;

   logic            accept;
   logic            rd_absent;
   logic [CW:0]     lidx, ridx;
   logic            cur_lt;
   logic            push_ok;
   logic [CW-1:0]   sp_dec;
   logic [8:0]      ql, qr;
   logic [6:0]      qp;
   logic            q_lt, ql_lt, qr_lt;
   logic [31:0]     biased;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rd_absent = (rd_data_ff == ABSENT);
   assign lidx      = {idx_ff, 1'b1};
   assign ridx      = lidx + (CW+1)'(1);
   assign cur_lt    = cur_ff < CURW'(count_ff);
   assign push_ok   = cur_lt && !rd_absent && (sp_ff < CW'(MAX_NODES));
   assign sp_dec    = sp_ff - CW'(1);
   assign stk_raddr = sp_dec[AW-1:0];
   assign ql        = {1'b0, q_ff, 1'b1};
   assign qr        = ql + 9'd1;
   assign qp        = (q_ff - 7'd1) >> 1;
   assign q_lt      = 32'(q_ff) < 32'(count_ff);
   assign ql_lt     = 32'(ql) < 32'(count_ff);
   assign qr_lt     = 32'(qr) < 32'(count_ff);
   assign biased    = rd_data_ff ^ SIGN_BIT;
   assign wr_en     = accept && (req_opcode == OP_APPEND) && (count_ff < CW'(MAX_NODES));
   assign stk_we    = (state_ff == ST_WK_CHECK) && push_ok;

   always_comb begin
      unique case (state_ff)
         ST_SC_NODE:  rd_addr = AW'(idx_ff);
         ST_SC_LEFT:  rd_addr = AW'(lidx);
         ST_SC_RIGHT: rd_addr = AW'(ridx);
         ST_WK_READ:  rd_addr = AW'(cur_ff);
         ST_WK_POP:   rd_addr = stk_data_ff;
         ST_Q_NODE:   rd_addr = AW'(q_ff);
         ST_Q_PARENT: rd_addr = AW'(qp);
         ST_Q_LEFT:   rd_addr = AW'(ql);
         ST_Q_RIGHT:  rd_addr = AW'(qr);
         default:     rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_store[count_ff[AW-1:0]] <= req_node_value;
      end
      rd_data_ff <= node_store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         walk_stack[sp_ff[AW-1:0]] <= cur_ff[AW-1:0];
      end
      stk_data_ff <= walk_stack[stk_raddr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_ANALYZE) state_in = ST_SC_NODE;
         end
         ST_SC_NODE:  state_in = (idx_ff < count_ff) ? ST_SC_LEFT : ST_WK_READ;
         ST_SC_LEFT:  state_in = ST_SC_RIGHT;
         ST_SC_RIGHT: state_in = ST_SC_EVAL;
         ST_SC_EVAL:  state_in = ST_SC_NODE;
         ST_WK_READ:  state_in = ST_WK_CHECK;
         ST_WK_CHECK: begin
            if (push_ok)              state_in = ST_WK_READ;
            else if (sp_ff == '0)     state_in = ST_Q_NODE;
            else                      state_in = ST_WK_POP;
         end
         ST_WK_POP:   state_in = ST_WK_VISIT;
         ST_WK_VISIT: state_in = (biased <= prev_ff) ? ST_Q_NODE : ST_WK_READ;
         ST_Q_NODE:   state_in = ST_Q_PARENT;
         ST_Q_PARENT: state_in = ST_Q_LEFT;
         ST_Q_LEFT:   state_in = ST_Q_RIGHT;
         ST_Q_RIGHT:  state_in = ST_Q_EVAL;
         ST_Q_EVAL:   state_in = ST_RESP;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      node_pres_in = node_pres_ff;
      lpres_in     = lpres_ff;
      any_in       = any_ff;
      gap_in       = gap_ff;
      seen_in      = seen_ff;
      int_in       = int_ff;
      leaf_in      = leaf_ff;
      cur_in       = cur_ff;
      sp_in        = sp_ff;
      prev_in      = prev_ff;
      ok_in        = ok_ff;
      q_in         = q_ff;
      qpres_in     = qpres_ff;
      qv_in        = qv_ff;
      pv_in        = pv_ff;
      lv_in        = lv_ff;
      rv_in        = rv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_CLEAR: count_in = '0;
                  OP_APPEND: begin
                     if (wr_en) count_in = count_ff + CW'(1);
                  end
                  OP_ANALYZE: begin
                     idx_in  = '0;
                     any_in  = 1'b0;
                     gap_in  = 1'b0;
                     seen_in = 1'b0;
                     int_in  = '0;
                     leaf_in = '0;
                     q_in    = req_query_index;
                  end
                  default: ;
               endcase
            end
         end
         ST_SC_NODE: begin
            if (!(idx_ff < count_ff)) begin
               cur_in  = '0;
               sp_in   = '0;
               prev_in = '0;
               ok_in   = 1'b1;
            end
         end
         ST_SC_LEFT:  node_pres_in = !rd_absent;
         ST_SC_RIGHT: lpres_in = (lidx < {1'b0, count_ff}) && !rd_absent;
         ST_SC_EVAL: begin
            if (node_pres_ff) begin
               any_in = 1'b1;
               if (seen_ff) gap_in = 1'b1;
               if (lpres_ff || ((ridx < {1'b0, count_ff}) && !rd_absent)) begin
                  int_in = int_ff + CW'(1);
               end else begin
                  leaf_in = leaf_ff + CW'(1);
               end
            end else begin
               seen_in = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
         end
         ST_WK_CHECK: begin
            if (push_ok) begin
               sp_in  = sp_ff + CW'(1);
               cur_in = CURW'({cur_ff, 1'b1});
            end else if (sp_ff != '0) begin
               sp_in = sp_dec;
            end
         end
         ST_WK_POP: cur_in = CURW'(stk_data_ff);
         ST_WK_VISIT: begin
            if (biased <= prev_ff) begin
               ok_in = 1'b0;
            end else begin
               prev_in = biased;
               cur_in  = CURW'({cur_ff, 1'b1}) + CURW'(1);
            end
         end
         ST_Q_PARENT: begin
            qv_in    = rd_data_ff;
            qpres_in = q_lt && !rd_absent;
         end
         ST_Q_LEFT:  pv_in = rd_data_ff;
         ST_Q_RIGHT: lv_in = ql_lt ? rd_data_ff : ABSENT;
         ST_Q_EVAL:  rv_in = qr_lt ? rd_data_ff : ABSENT;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff       <= idx_in;
      node_pres_ff <= node_pres_in;
      lpres_ff     <= lpres_in;
      any_ff       <= any_in;
      gap_ff       <= gap_in;
      seen_ff      <= seen_in;
      int_ff       <= int_in;
      leaf_ff      <= leaf_in;
      cur_ff       <= cur_in;
      sp_ff        <= sp_in;
      prev_ff      <= prev_in;
      ok_ff        <= ok_in;
      q_ff         <= q_in;
      qpres_ff     <= qpres_in;
      qv_ff        <= qv_in;
      pv_ff        <= pv_in;
      lv_ff        <= lv_in;
      rv_ff        <= rv_in;
   end

   assign rsp_valid          = (state_ff == ST_RESP);
   assign rsp_tree_empty     = !any_ff;
   assign rsp_has_gaps       = gap_ff;
   assign rsp_internal_count = 7'(int_ff);
   assign rsp_leaf_count     = 7'(leaf_ff);
   assign rsp_bst_ok         = ok_ff;
   assign rsp_query_valid    = qpres_ff;
   assign rsp_query_value    = qpres_ff ? qv_ff : '0;
   assign rsp_has_parent     = qpres_ff && (q_ff != '0);
   assign rsp_parent_value   = rsp_has_parent ? pv_ff : '0;
   assign rsp_left_value     = qpres_ff ? lv_ff : ABSENT;
   assign rsp_right_value    = qpres_ff ? rv_ff : ABSENT;
   assign rsp_degree         = qpres_ff ? (2'(lv_ff != ABSENT) + 2'(rv_ff != ABSENT)) : 2'd0;

endmodule

// ===== hw/rtl/ata_checker.sv =====
`include "array_tree_analyzer_assert.svh"

module ata_checker
   import ata_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_opcode,
   input logic               rsp_valid,
   input logic               rsp_tree_empty,
   input logic [6:0]         rsp_internal_count,
   input logic [6:0]         rsp_leaf_count,
   input logic               rsp_query_valid,
   input logic signed [31:0] rsp_left_value,
   input logic signed [31:0] rsp_right_value
);

   `ATA_ASSERT_NEXT(a_analyze_busy, clock, reset, start && !busy && req_opcode == OP_ANALYZE, busy)
   `ATA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `ATA_ASSERT_NOW(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `ATA_ASSERT_NOW(a_empty_counts, clock, reset, rsp_valid && rsp_tree_empty, rsp_internal_count == 7'd0 && rsp_leaf_count == 7'd0)
   `ATA_ASSERT_NOW(a_invalid_children, clock, reset, rsp_valid && !rsp_query_valid, rsp_left_value == ABSENT && rsp_right_value == ABSENT)

endmodule

bind array_tree_analyzer ata_checker u_ata_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_opcode         (req_opcode),
   .rsp_valid          (rsp_valid),
   .rsp_tree_empty     (rsp_tree_empty),
   .rsp_internal_count (rsp_internal_count),
   .rsp_leaf_count     (rsp_leaf_count),
   .rsp_query_valid    (rsp_query_valid),
   .rsp_left_value     (rsp_left_value),
   .rsp_right_value    (rsp_right_value)
);

// ===== tb/sv/tb_array_tree_analyzer.sv =====
module tb_array_tree_analyzer;
   import ata_pkg::*;

   localparam int DEPTH      = 64;
   localparam int IDLE_LIMIT = 4000;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic        tree_empty;
      logic        has_gaps;
      logic [6:0]  internal_count;
      logic [6:0]  leaf_count;
      logic        bst_ok;
      logic        query_valid;
      logic [31:0] query_value;
      logic        has_parent;
      logic [31:0] parent_value;
      logic [31:0] left_value;
      logic [31:0] right_value;
      logic [1:0]  degree;
   } tree_report_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic signed [31:0] req_node_value;
   logic [6:0]         req_query_index;
   logic               rsp_valid;
   logic               rsp_tree_empty;
   logic               rsp_has_gaps;
   logic [6:0]         rsp_internal_count;
   logic [6:0]         rsp_leaf_count;
   logic               rsp_bst_ok;
   logic               rsp_query_valid;
   logic signed [31:0] rsp_query_value;
   logic               rsp_has_parent;
   logic signed [31:0] rsp_parent_value;
   logic signed [31:0] rsp_left_value;
   logic signed [31:0] rsp_right_value;
   logic [1:0]         rsp_degree;

   logic [31:0]     tree_mem [DEPTH];
   int unsigned     tree_size;
   tree_report_type pending_reports [$];
   int              error_count;
   int              idle_cycles;
   int              burst_left;

   array_tree_analyzer dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic bit node_present(int unsigned idx);
      return idx < tree_size && tree_mem[idx] != ABSENT;
   endfunction

   function automatic logic [31:0] node_or_absent(int unsigned idx);
      return idx < tree_size ? tree_mem[idx] : ABSENT;
   endfunction

   function automatic bit inorder_increasing();
      int unsigned walk [DEPTH];
      int unsigned cur;
      int unsigned sp;
      logic [31:0] prev;
      logic [31:0] biased;
      cur = 0;
      sp = 0;
      prev = '0;
      forever begin
         while (node_present(cur) && sp < DEPTH) begin
            walk[sp] = cur;
            sp++;
            cur = 2 * cur + 1;
         end
         if (sp == 0) return 1'b1;
         sp--;
         cur = walk[sp];
         biased = tree_mem[cur] ^ SIGN_BIT;
         if (biased <= prev) return 1'b0;
         prev = biased;
         cur = 2 * cur + 2;
      end
   endfunction

   function automatic tree_report_type analyze_tree(int unsigned q);
      tree_report_type r;
      bit any;
      int unsigned last;
      int unsigned n_int;
      int unsigned n_leaf;
      any = 0;
      last = 0;
      n_int = 0;
      n_leaf = 0;
      r.has_gaps = 1'b0;
      for (int unsigned i = 0; i < tree_size; i++) begin
         if (tree_mem[i] != ABSENT) begin
            any = 1;
            last = i;
            if (node_present(2 * i + 1) || node_present(2 * i + 2)) n_int++;
            else n_leaf++;
         end
      end
      for (int unsigned i = 0; any && i < last; i++)
         if (tree_mem[i] == ABSENT) r.has_gaps = 1'b1;
      r.tree_empty = !any;
      r.internal_count = n_int[6:0];
      r.leaf_count = n_leaf[6:0];
      r.bst_ok = inorder_increasing();
      if (node_present(q)) begin
         r.query_valid = 1'b1;
         r.query_value = tree_mem[q];
         r.has_parent = q != 0;
         r.parent_value = q != 0 ? tree_mem[(q - 1) / 2] : '0;
         r.left_value = node_or_absent(2 * q + 1);
         r.right_value = node_or_absent(2 * q + 2);
         r.degree = 2'(node_present(2 * q + 1)) + 2'(node_present(2 * q + 2));
      end else begin
         r.query_valid = 1'b0;
         r.query_value = '0;
         r.has_parent = 1'b0;
         r.parent_value = '0;
         r.left_value = ABSENT;
         r.right_value = ABSENT;
         r.degree = '0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", field, got, want);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      tree_report_type w;
      if (!reset && rsp_valid) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected result transfer", 32'd1, 32'd0);
         end else begin
            w = pending_reports.pop_front();
            if (rsp_tree_empty !== w.tree_empty)
               report_mismatch("tree_empty", 32'(rsp_tree_empty), 32'(w.tree_empty));
            if (rsp_has_gaps !== w.has_gaps)
               report_mismatch("has_gaps", 32'(rsp_has_gaps), 32'(w.has_gaps));
            if (rsp_internal_count !== w.internal_count)
               report_mismatch("internal_count", 32'(rsp_internal_count),
                               32'(w.internal_count));
            if (rsp_leaf_count !== w.leaf_count)
               report_mismatch("leaf_count", 32'(rsp_leaf_count), 32'(w.leaf_count));
            if (rsp_bst_ok !== w.bst_ok)
               report_mismatch("bst_ok", 32'(rsp_bst_ok), 32'(w.bst_ok));
            if (rsp_query_valid !== w.query_valid)
               report_mismatch("query_valid", 32'(rsp_query_valid), 32'(w.query_valid));
            if (rsp_query_value !== w.query_value)
               report_mismatch("query_value", rsp_query_value, w.query_value);
            if (rsp_has_parent !== w.has_parent)
               report_mismatch("has_parent", 32'(rsp_has_parent), 32'(w.has_parent));
            if (rsp_parent_value !== w.parent_value)
               report_mismatch("parent_value", rsp_parent_value, w.parent_value);
            if (rsp_left_value !== w.left_value)
               report_mismatch("left_value", rsp_left_value, w.left_value);
            if (rsp_right_value !== w.right_value)
               report_mismatch("right_value", rsp_right_value, w.right_value);
            if (rsp_degree !== w.degree)
               report_mismatch("degree", 32'(rsp_degree), 32'(w.degree));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_cmd(logic [1:0] op, logic [31:0] value, logic [6:0] qidx);
      int gap;
      @(negedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_node_value <= value;
      req_query_index <= qidx;
      do @(posedge clock); while (busy);
      case (op)
         OP_CLEAR: tree_size = 0;
         OP_APPEND: begin
            if (tree_size < DEPTH) begin
               tree_mem[tree_size] = value;
               tree_size++;
            end
         end
         OP_ANALYZE: pending_reports.push_back(analyze_tree(qidx));
         default: ;
      endcase
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 8);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return ABSENT;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return $urandom_range(0, 200);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_cmd(OP_ANALYZE, '0, 7'd0);
      send_cmd(OP_ANALYZE, '1, 7'd127);
      send_cmd(OP_APPEND, 32'd50, '0);
      send_cmd(OP_ANALYZE, '0, 7'd0);
      send_cmd(OP_APPEND, 32'h8000_0000, '0);
      send_cmd(OP_APPEND, 32'h7FFF_FFFF, '0);
      send_cmd(OP_ANALYZE, '0, 7'd0);
      send_cmd(OP_ANALYZE, '0, 7'd1);
      send_cmd(OP_ANALYZE, '0, 7'd2);
      send_cmd(OP_APPEND, ABSENT, '0);
      send_cmd(OP_APPEND, 32'd0, '0);
      send_cmd(OP_UNUSED, 32'd99, 7'd5);
      send_cmd(OP_ANALYZE, '0, 7'd3);
      send_cmd(OP_ANALYZE, '0, 7'd4);
      send_cmd(OP_ANALYZE, '0, 7'd5);
      send_cmd(OP_CLEAR, '1, 7'd127);
      send_cmd(OP_APPEND, ABSENT, '0);
      send_cmd(OP_ANALYZE, '0, 7'd0);
      send_cmd(OP_CLEAR, '0, '0);
   endtask

   task automatic test_full_store();
      for (int i = 0; i < DEPTH + 3; i++) send_cmd(OP_APPEND, 32'(i * 3 - 90), '0);
      send_cmd(OP_ANALYZE, '0, 7'd31);
      send_cmd(OP_ANALYZE, '0, 7'd63);
      send_cmd(OP_ANALYZE, '0, 7'd64);
      send_cmd(OP_CLEAR, '0, '0);
   endtask

   // complete trees filled in order, with holes and the odd broken key
   task automatic test_search_trees(int rounds);
      logic [31:0] keys [DEPTH];
      int unsigned walk [DEPTH];
      int unsigned n;
      int unsigned sp;
      int unsigned cur;
      int          key;
      for (int r = 0; r < rounds; r++) begin
         n = $urandom_range(0, 5) == 0 ? $urandom_range(40, DEPTH) : $urandom_range(1, 15);
         key = $urandom_range(0, 1) ? -$urandom_range(0, 1000) : $urandom;
         sp = 0;
         cur = 0;
         forever begin
            while (cur < n) begin
               walk[sp] = cur;
               sp++;
               cur = 2 * cur + 1;
            end
            if (sp == 0) break;
            sp--;
            cur = walk[sp];
            key += $urandom_range(1, 1000);
            keys[cur] = key;
            if (keys[cur] == ABSENT) keys[cur] = 32'd7;
            cur = 2 * cur + 2;
         end
         if ($urandom_range(0, 2) == 0) keys[$urandom_range(0, n - 1)] = ABSENT;
         if ($urandom_range(0, 3) == 0) keys[$urandom_range(0, n - 1)] = random_value();
         send_cmd(OP_CLEAR, $urandom, 7'($urandom));
         for (int unsigned i = 0; i < n; i++) send_cmd(OP_APPEND, keys[i], 7'($urandom));
         repeat ($urandom_range(1, 3))
            send_cmd(OP_ANALYZE, $urandom,
                     7'($urandom_range(0, 1) ? $urandom_range(0, n) : $urandom));
      end
   endtask

   task automatic test_random_noise(int count);
      int p;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(0, 19);
         if (p == 0) send_cmd(OP_CLEAR, $urandom, 7'($urandom));
         else if (p == 1) send_cmd(OP_UNUSED, $urandom, 7'($urandom));
         else if (p < 6) send_cmd(OP_ANALYZE, $urandom, 7'($urandom));
         else send_cmd(OP_APPEND, random_value(), 7'($urandom));
      end
   endtask

   initial begin
      error_count = 0;
      idle_cycles = 0;
      burst_left = 0;
      tree_size = 0;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_CLEAR;
      req_node_value = '0;
      req_query_index = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_store();
      wait_drained();
      test_search_trees(30);
      wait_drained();
      test_random_noise(100);
      wait_drained();
      @(negedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
